/* rtl/lag_pkg.sv */
// Package for the life automaton grid: shared types, codes and constants.
// Used by lag_window and life_automaton_grid_unit; depends on nothing else.
`timescale 1ns / 1ps

package lag_pkg;

  // Default grid bounds, handed to the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Width of the compare path; holds a 4096 bound plus a carry with margin.
  localparam int CMP_W = 14;

  // Width of the size registers.
  localparam int SIZE_W = 9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // B3/S23 neighbour counts.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [1:0] {
    OP_PLACE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_e;

  // Row of the neighbourhood column that a read fetches.
  typedef enum logic [1:0] {
    SLOT_UP   = 2'd0,
    SLOT_MID  = 2'd1,
    SLOT_DOWN = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PLACE,
    ST_READ,
    ST_ADV,
    ST_DRAIN,
    ST_RESP
  } state_e;

  // Control beat travelling with a grid read towards the window.
  typedef struct packed {
    logic  valid;
    logic  in_range;
    slot_e slot;
    logic  first_col;
  } win_ctl_t;

endpackage

/* rtl/lag_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module lag_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lag_window.sv */
// Sliding 3x3 neighbourhood window and B3/S23 rule for the generation sweep.
// Depends on lag_pkg for the control beat and the rule constants.
`timescale 1ns / 1ps

module lag_window
  import lag_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  win_ctl_t ctl_i,
  input  logic     bit_i,
  output logic     next_alive_o,
  output logic     col_done_o
);

  logic       up_q, up_d;
  logic       mid_q, mid_d;
  logic [2:0] left_q, left_d;
  logic [2:0] ctr_q, ctr_d;
  logic [2:0] new_col;
  logic       bit_in;
  logic [3:0] count;

  // Out-of-grid neighbours read as dead.
  assign bit_in  = ctl_i.in_range & bit_i;
  assign new_col = {bit_in, mid_q, up_q};

  assign count = 4'(left_q[0]) + 4'(left_q[1]) + 4'(left_q[2])
               + 4'(ctr_q[0]) + 4'(ctr_q[2])
               + 4'(new_col[0]) + 4'(new_col[1]) + 4'(new_col[2]);

  assign next_alive_o = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && ctr_q[1]);
  assign col_done_o   = ctl_i.valid && (ctl_i.slot == SLOT_DOWN);

  always_comb begin
    up_d   = up_q;
    mid_d  = mid_q;
    left_d = left_q;
    ctr_d  = ctr_q;
    if (ctl_i.valid) begin
      unique case (ctl_i.slot)
        SLOT_UP:   up_d  = bit_in;
        SLOT_MID:  mid_d = bit_in;
        SLOT_DOWN: begin
          // Start of a row: nothing lies left of column zero.
          left_d = ctl_i.first_col ? 3'b000 : ctr_q;
          ctr_d  = new_col;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q   <= 1'b0;
      mid_q  <= 1'b0;
      left_q <= '0;
      ctr_q  <= '0;
    end else begin
      up_q   <= up_d;
      mid_q  <= mid_d;
      left_q <= left_d;
      ctr_q  <= ctr_d;
    end
  end

endmodule

/* rtl/life_automaton_grid_unit.sv */
// Life automaton grid (B3/S23, bounded, non-wrapping) with two grid banks.
// One item at a time: the next input beat is taken only once the result beat of
// the last item has been issued. DEPTH = MAX_HEIGHT*2**CW grid addresses.
// Reset: sizes 256x256, then a clearing pass over all DEPTH addresses (65536 at
// the defaults) with s_axis_tready low; a size change reruns that pass.
`timescale 1ns / 1ps

module life_automaton_grid_unit
  import lag_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Item stream in
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // [1:0] mode, [9:2] col, [17:10] row, zero pad
  // Result stream out
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [0] cell_alive, [1] applied, zero pad
  // Register writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [SIZE_W-1:0] cfg_data_i
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = CW + RW;
  localparam int DEPTH = MAX_HEIGHT * (2 ** CW);
  localparam int UW    = $clog2(MAX_WIDTH + 1);

  // ---------------------------------------------------------------------
  // Configuration: sizes held in registers; a change clears the grid.
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0] width_q, width_d;
  logic [SIZE_W-1:0] height_q, height_d;
  logic              cfg_fire;
  logic              cfg_clear;

  // Sequencer state, declared early for the register-write handshake.
  state_e           state_q, state_d;
  logic             from_item_q, from_item_d;

  // Take writes only with no item in flight; a changed size restarts a register clear.
  assign cfg_ready_o = (state_q == ST_IDLE) || ((state_q == ST_CLEAR) && !from_item_q);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    cfg_clear = 1'b0;
    if (cfg_fire) begin
      if (cfg_index_i == REG_WIDTH) begin
        width_d   = cfg_data_i;
        cfg_clear = (cfg_data_i != width_q);
      end else if (cfg_index_i == REG_HEIGHT) begin
        height_d  = cfg_data_i;
        cfg_clear = (cfg_data_i != height_q);
      end
    end
  end

  // Sizes clipped to the physical grid.
  logic [CMP_W-1:0] uw_x, uh_x;
  assign uw_x = (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(width_q);
  assign uh_x = (CMP_W'(height_q) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT)
                                                        : CMP_W'(height_q);

  // ---------------------------------------------------------------------
  // Input beat decode
  // ---------------------------------------------------------------------
  op_e              in_mode;
  logic [7:0]       in_col, in_row;
  logic             s_fire;
  logic             place_ok, read_ok;

  assign in_mode = op_e'(s_axis_tdata[1:0]);
  assign in_col  = s_axis_tdata[9:2];
  assign in_row  = s_axis_tdata[17:10];
  assign s_fire  = s_axis_tvalid && s_axis_tready;

  // Block fits when col+1 < w and row+1 < h.
  assign place_ok = ((CMP_W'(in_col) + CMP_W'(1)) < uw_x) &&
                    ((CMP_W'(in_row) + CMP_W'(1)) < uh_x);
  assign read_ok  = (CMP_W'(in_col) < uw_x) && (CMP_W'(in_row) < uh_x);

  // ---------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------
  logic             cur_q, cur_d;          // bank that holds the live grid
  logic [AW-1:0]    clr_q, clr_d;          // clearing pass address
  logic [1:0]       step_q, step_d;        // placement corner
  logic [1:0]       k_q, k_d;              // neighbourhood row of the next read
  logic [UW-1:0]    cc_q, cc_d;            // leading column of the sweep
  logic [RW-1:0]    r_q, r_d;              // row being built
  op_e              mode_q, mode_d;
  logic [7:0]       col_q, col_d, row_q, row_d;
  logic             applied_q, applied_d;
  win_ctl_t         win_ctl_q, win_ctl_d;
  logic [UW-1:0]    wcol_q, wcol_d;
  logic [RW-1:0]    wrow_q, wrow_d;
  logic             m_valid_q, m_valid_d;
  logic             m_alive_q, m_alive_d;
  logic             m_applied_q, m_applied_d;

  logic             clr_last;
  logic             issue_last;
  logic             out_free;
  logic             grid_empty;

  assign clr_last   = (clr_q == AW'(DEPTH - 1));
  assign issue_last = (k_q == SLOT_DOWN) && (CMP_W'(cc_q) == uw_x) &&
                      ((CMP_W'(r_q) + CMP_W'(1)) == uh_x);
  assign out_free   = !m_valid_q || m_axis_tready;
  assign grid_empty = (uw_x == '0) || (uh_x == '0);

  // Hold the input while a register write lands in the same cycle.
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_fire;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_clear) begin
          state_d = ST_CLEAR;
        end else if (s_fire) begin
          unique case (in_mode)
            OP_PLACE:   state_d = place_ok ? ST_PLACE : ST_RESP;
            OP_ADVANCE: state_d = grid_empty ? ST_RESP : ST_ADV;
            OP_READ:    state_d = ST_READ;
            OP_CLEAR:   state_d = ST_CLEAR;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_CLEAR: begin
        if (cfg_clear) begin
          state_d = ST_CLEAR;
        end else if (clr_last) begin
          state_d = from_item_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_PLACE: if (step_q == 2'd3) state_d = ST_RESP;
      ST_READ:  state_d = ST_RESP;
      ST_ADV:   if (issue_last) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_RESP;
      ST_RESP:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Memory access and datapath
  // ---------------------------------------------------------------------
  logic              rd_en;
  logic [CW-1:0]     rd_col;
  logic [RW-1:0]     rd_row;
  logic              we_cur;
  logic [AW-1:0]     waddr_cur;
  logic              wdata_cur;
  logic              we_nxt;
  logic [AW-1:0]     waddr_nxt;
  logic              rdata0, rdata1, rdata_cur;
  logic              next_alive, col_done;
  logic [CMP_W-1:0]  rr_x, rr_m1;
  logic              adv_in_range;
  logic [CMP_W-1:0]  pcol_x, prow_x;
  logic [CMP_W-1:0]  wcol_m1;

  assign rdata_cur = cur_q ? rdata1 : rdata0;

  // Sweep read position: row r-1+k of the leading column.
  assign rr_x         = CMP_W'(r_q) + CMP_W'(k_q);
  assign rr_m1        = rr_x - CMP_W'(1);
  assign adv_in_range = (rr_x != '0) && (rr_x <= uh_x) && (CMP_W'(cc_q) < uw_x);

  assign pcol_x  = CMP_W'(col_q) + CMP_W'(step_q[0]);
  assign prow_x  = CMP_W'(row_q) + CMP_W'(step_q[1]);
  assign wcol_m1 = CMP_W'(wcol_q) - CMP_W'(1);

  // Finished column: write the centre cell into the other bank.
  assign we_nxt    = col_done && !win_ctl_q.first_col;
  assign waddr_nxt = {wrow_q, wcol_m1[CW-1:0]};

  always_comb begin
    cur_d       = cur_q;
    clr_d       = clr_q;
    from_item_d = from_item_q;
    step_d      = step_q;
    k_d         = k_q;
    cc_d        = cc_q;
    r_d         = r_q;
    mode_d      = mode_q;
    col_d       = col_q;
    row_d       = row_q;
    applied_d   = applied_q;
    win_ctl_d   = '{valid: 1'b0, in_range: 1'b0, slot: SLOT_UP, first_col: 1'b0};
    wcol_d      = wcol_q;
    wrow_d      = wrow_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_alive_d   = m_alive_q;
    m_applied_d = m_applied_q;
    rd_en       = 1'b0;
    rd_col      = '0;
    rd_row      = '0;
    we_cur      = 1'b0;
    waddr_cur   = clr_q;
    wdata_cur   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_clear) begin
          clr_d       = '0;
          from_item_d = 1'b0;
        end else if (s_fire) begin
          mode_d      = in_mode;
          col_d       = in_col;
          row_d       = in_row;
          step_d      = '0;
          k_d         = SLOT_UP;
          cc_d        = '0;
          r_d         = '0;
          clr_d       = '0;
          from_item_d = 1'b1;
          unique case (in_mode)
            OP_PLACE: applied_d = place_ok;
            OP_READ:  applied_d = read_ok;
            default:  applied_d = 1'b1;
          endcase
        end
      end
      ST_CLEAR: begin
        we_cur    = 1'b1;
        waddr_cur = clr_q;
        wdata_cur = 1'b0;
        if (cfg_clear) begin
          clr_d       = '0;
          from_item_d = 1'b0;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_PLACE: begin
        we_cur    = 1'b1;
        waddr_cur = {prow_x[RW-1:0], pcol_x[CW-1:0]};
        wdata_cur = 1'b1;
        step_d    = step_q + 2'd1;
      end
      ST_READ: begin
        rd_en  = applied_q;
        rd_col = CW'(CMP_W'(col_q));
        rd_row = RW'(CMP_W'(row_q));
      end
      ST_ADV: begin
        rd_en  = adv_in_range;
        rd_col = cc_q[CW-1:0];
        rd_row = rr_m1[RW-1:0];
        win_ctl_d = '{valid: 1'b1, in_range: adv_in_range, slot: slot_e'(k_q),
                      first_col: (cc_q == '0)};
        wcol_d = cc_q;
        wrow_d = r_q;
        // Advance: row slot, then column, then row.
        if (k_q == SLOT_DOWN) begin
          k_d = SLOT_UP;
          if (CMP_W'(cc_q) == uw_x) begin
            cc_d = '0;
            r_d  = r_q + RW'(1);
          end else begin
            cc_d = cc_q + UW'(1);
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        // Last column lands this cycle; the new generation becomes live.
        cur_d = !cur_q;
      end
      ST_RESP: begin
        if (out_free) begin
          m_valid_d   = 1'b1;
          m_applied_d = applied_q;
          m_alive_d   = (mode_q == OP_READ) && applied_q && rdata_cur;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_q       <= 1'b0;
      clr_q       <= '0;
      from_item_q <= 1'b0;
      width_q     <= SIZE_RESET;
      height_q    <= SIZE_RESET;
      win_ctl_q   <= '{valid: 1'b0, in_range: 1'b0, slot: SLOT_UP, first_col: 1'b0};
      m_valid_q   <= 1'b0;
      step_q      <= '0;
      k_q         <= SLOT_UP;
      cc_q        <= '0;
      r_q         <= '0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      clr_q       <= clr_d;
      from_item_q <= from_item_d;
      width_q     <= width_d;
      height_q    <= height_d;
      win_ctl_q   <= win_ctl_d;
      m_valid_q   <= m_valid_d;
      step_q      <= step_d;
      k_q         <= k_d;
      cc_q        <= cc_d;
      r_q         <= r_d;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    col_q       <= col_d;
    row_q       <= row_d;
    applied_q   <= applied_d;
    wcol_q      <= wcol_d;
    wrow_q      <= wrow_d;
    m_alive_q   <= m_alive_d;
    m_applied_q <= m_applied_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_applied_q, m_alive_q};

  // ---------------------------------------------------------------------
  // Grid banks: the live bank takes clears and placements, the other bank
  // takes the generation being built. The schedule never reads and writes
  // one bank in the same cycle, so no forwarding is needed.
  // ---------------------------------------------------------------------
  logic          we0, we1;
  logic [AW-1:0] waddr0, waddr1;
  logic          wdata0, wdata1;
  logic [AW-1:0] raddr;

  assign raddr  = {rd_row, rd_col};
  assign we0    = cur_q ? we_nxt : we_cur;
  assign we1    = cur_q ? we_cur : we_nxt;
  assign waddr0 = cur_q ? waddr_nxt : waddr_cur;
  assign waddr1 = cur_q ? waddr_cur : waddr_nxt;
  assign wdata0 = cur_q ? next_alive : wdata_cur;
  assign wdata1 = cur_q ? wdata_cur : next_alive;

  lag_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr0),
    .wdata_i (wdata0),
    .re_i    (rd_en && !cur_q),
    .raddr_i (raddr),
    .rdata_o (rdata0)
  );

  lag_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr1),
    .wdata_i (wdata1),
    .re_i    (rd_en && cur_q),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  lag_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (win_ctl_q),
    .bit_i        (rdata_cur),
    .next_alive_o (next_alive),
    .col_done_o   (col_done)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_one_bank_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we0 && we1))
    else $error("both grid banks written in one cycle");

  a_sweep_read_in_grid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && state_q == ST_ADV) |-> (CMP_W'(rd_row) < uh_x) && (CMP_W'(rd_col) < uw_x))
    else $error("generation sweep reads outside the grid in use");

  a_new_gen_write_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_nxt |-> (state_q == ST_ADV || state_q == ST_DRAIN))
    else $error("new generation written outside a sweep");

  a_bank_flip_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q != $past(cur_q)) |-> ($past(state_q) == ST_DRAIN))
    else $error("live bank changed outside the end of a sweep");

endmodule

/* tb/tb_top.sv */
// Self-checking bench for life_automaton_grid_unit: directed and random item streams
// against a cycle-free B3/S23 grid predictor, with size changes and back-pressure.
// Depends on rtl/lag_pkg.sv and rtl/life_automaton_grid_unit.sv, which needs rtl/lag_window.sv and rtl/lag_ram.sv.
`timescale 1ns / 1ps

module tb_top
  import lag_pkg::*;
();

  localparam int GRID_COLS = MAX_WIDTH_DEF;
  localparam int GRID_ROWS = MAX_HEIGHT_DEF;
  // Index outside the register map; the block must ignore it.
  localparam logic [1:0] REG_NONE = 2'd3;
  // Pause after the last result before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 20;
  // Overall guard; the slowest legal run is well under a fifth of this.
  localparam longint RUN_LIMIT_NS = 64'd80_000_000;

  typedef struct packed {
    logic applied;
    logic cell_alive;
  } item_outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata = '0;   // [1:0] mode, [9:2] col, [17:10] row, zero pad
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // [0] cell_alive, [1] applied, zero pad
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [SIZE_W-1:0] cfg_data_i = '0;

  // Predictor state: raw size registers and the live grid, cell (c, r) at r*GRID_COLS + c.
  int unsigned   size_cols_reg = 256;
  int unsigned   size_rows_reg = 256;
  bit            live_cells [0:GRID_COLS*GRID_ROWS-1];
  bit            next_cells [0:GRID_COLS*GRID_ROWS-1];
  item_outcome_t pending_outcomes [$];

  int mismatch_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold_cycles = 0;

  life_automaton_grid_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------

  // Register values above the grid bound clamp to the bound.
  function automatic int used_cols();
    return (size_cols_reg > GRID_COLS) ? GRID_COLS : int'(size_cols_reg);
  endfunction

  function automatic int used_rows();
    return (size_rows_reg > GRID_ROWS) ? GRID_ROWS : int'(size_rows_reg);
  endfunction

  function automatic void wipe_cells();
    for (int i = 0; i < GRID_COLS*GRID_ROWS; i++) live_cells[i] = 1'b0;
  endfunction

  // One B3/S23 generation over the cells in use; cells off the grid count as dead.
  function automatic void evolve_cells();
    int w;
    int h;
    int n;
    w = used_cols();
    h = used_rows();
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < h &&
                c + dc >= 0 && c + dc < w)
              n += live_cells[(r + dr)*GRID_COLS + c + dc];
          end
        end
        next_cells[r*GRID_COLS + c] = (n == int'(BIRTH_COUNT)) ||
            (n == int'(SURVIVE_COUNT) && live_cells[r*GRID_COLS + c]);
      end
    end
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) live_cells[r*GRID_COLS + c] = next_cells[r*GRID_COLS + c];
  endfunction

  function automatic item_outcome_t apply_item(op_e mode, logic [7:0] col, logic [7:0] row);
    item_outcome_t o;
    int w;
    int h;
    int c;
    int r;
    w = used_cols();
    h = used_rows();
    c = int'(col);
    r = int'(row);
    o.cell_alive = 1'b0;
    o.applied    = 1'b1;
    case (mode)
      OP_PLACE: begin
        // The whole 2x2 block must fit, else nothing changes.
        if (c + 1 >= w || r + 1 >= h) begin
          o.applied = 1'b0;
        end else begin
          live_cells[r*GRID_COLS + c]           = 1'b1;
          live_cells[r*GRID_COLS + c + 1]       = 1'b1;
          live_cells[(r + 1)*GRID_COLS + c]     = 1'b1;
          live_cells[(r + 1)*GRID_COLS + c + 1] = 1'b1;
        end
      end
      OP_ADVANCE: begin
        evolve_cells();
      end
      OP_READ: begin
        if (c >= w || r >= h) o.applied = 1'b0;
        else o.cell_alive = live_cells[r*GRID_COLS + c];
      end
      default: begin
        wipe_cells();
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one item, idling first at the current sender rate. Valid stays high
  // on return so that back-to-back items need no gap; wait_idle drops it.
  task automatic send_item(op_e mode, logic [7:0] col, logic [7:0] row);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, row, col, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_outcomes.push_back(apply_item(mode, col, row));
  endtask

  // Drop valid, wait until every expected result has come, then settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; a changed size wipes the grid, the same size keeps it.
  task automatic write_register(logic [1:0] idx, logic [SIZE_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_WIDTH && value != size_cols_reg) begin
      size_cols_reg = 32'(value);
      wipe_cells();
    end else if (idx == REG_HEIGHT && value != size_rows_reg) begin
      size_rows_reg = 32'(value);
      wipe_cells();
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall at the current rate, or hold off for a counted stretch.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles = sink_hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Compare each result beat with the oldest outstanding prediction.
  initial begin
    item_outcome_t want;
    item_outcome_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = item_outcome_t'(m_axis_tdata[1:0]);
        if (pending_outcomes.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing outstanding: expected none, actual %b",
                   $time, got);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.cell_alive !== want.cell_alive) begin
            mismatch_count++;
            $display("%0t: cell_alive mismatch: expected %b, actual %b",
                     $time, want.cell_alive, got.cell_alive);
          end
          if (got.applied !== want.applied) begin
            mismatch_count++;
            $display("%0t: applied mismatch: expected %b, actual %b",
                     $time, want.applied, got.applied);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full 256x256 grid out of reset: corners, edge rejects, one full generation, clear.
  task automatic test_full_grid();
    send_item(OP_PLACE, 8'd0, 8'd0);
    send_item(OP_PLACE, 8'd254, 8'd254);
    send_item(OP_PLACE, 8'd255, 8'd10);     // crosses the right edge
    send_item(OP_PLACE, 8'd10, 8'd255);     // crosses the bottom edge
    send_item(OP_PLACE, 8'd100, 8'd100);
    send_item(OP_PLACE, 8'd101, 8'd101);    // overlap makes a shape that evolves
    send_item(OP_READ, 8'd255, 8'd255);
    send_item(OP_READ, 8'd2, 8'd2);
    send_item(OP_ADVANCE, 8'hff, 8'hff);
    send_item(OP_READ, 8'd100, 8'd100);
    send_item(OP_READ, 8'd101, 8'd99);
    send_item(OP_CLEAR, 8'h55, 8'haa);
    send_item(OP_READ, 8'd0, 8'd0);
    wait_idle();
  endtask

  // Oversized, empty, single-column and smallest useful grids; unknown index;
  // rewrite of an unchanged size must keep the cells.
  task automatic test_size_extremes();
    write_register(REG_WIDTH, 9'h1ff);
    write_register(REG_HEIGHT, 9'd0);
    write_register(REG_NONE, 9'h1ff);
    send_item(OP_PLACE, 8'd0, 8'd0);
    send_item(OP_READ, 8'd0, 8'd0);
    send_item(OP_ADVANCE, 8'd0, 8'd0);
    wait_idle();

    write_register(REG_WIDTH, 9'd1);
    write_register(REG_HEIGHT, 9'd5);
    send_item(OP_PLACE, 8'd0, 8'd0);
    send_item(OP_READ, 8'd0, 8'd4);
    send_item(OP_READ, 8'd1, 8'd0);
    send_item(OP_READ, 8'd0, 8'd5);
    wait_idle();

    write_register(REG_WIDTH, 9'd2);
    write_register(REG_HEIGHT, 9'd2);
    send_item(OP_PLACE, 8'd0, 8'd0);
    send_item(OP_PLACE, 8'd1, 8'd0);
    send_item(OP_ADVANCE, 8'd0, 8'd0);
    send_item(OP_READ, 8'd1, 8'd1);
    wait_idle();
    write_register(REG_WIDTH, 9'd2);
    send_item(OP_READ, 8'd0, 8'd0);
    send_item(OP_CLEAR, 8'd0, 8'd0);
    send_item(OP_READ, 8'd0, 8'd0);
    wait_idle();
  endtask

  // Random traffic on the current grid: mostly in-grid placements and reads
  // with advances between them, a few off-grid coordinates, at most one clear.
  task automatic test_random_traffic(int item_count, int src_pct, int sink_pct,
                                     int hold_at, int pause_at);
    int w;
    int h;
    int pick;
    int clears_left;
    op_e mode;
    logic [7:0] col;
    logic [7:0] row;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    clears_left    = 1;
    w = used_cols();
    h = used_rows();
    for (int i = 0; i < item_count; i++) begin
      // Long receiver hold-off: the block fills and must stall its input.
      if (i == hold_at) sink_hold_cycles = 400;
      if (i == pause_at) wait_idle();
      pick = $urandom_range(99);
      col  = 8'($urandom_range(w - 1));
      row  = 8'($urandom_range(h - 1));
      if ($urandom_range(99) < 12) begin
        col = 8'($urandom);
        row = 8'($urandom);
      end
      if (pick < 45) begin
        mode = OP_PLACE;
      end else if (pick < 75) begin
        mode = OP_READ;
      end else if (pick < 98 || clears_left == 0) begin
        mode = OP_ADVANCE;
      end else begin
        mode = OP_CLEAR;
        clears_left--;
      end
      send_item(mode, col, row);
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_full_grid();
    test_size_extremes();

    write_register(REG_WIDTH, 9'd16);
    write_register(REG_HEIGHT, 9'd12);
    test_random_traffic(20, 0, 0, 5, -1);
    test_random_traffic(20, 73, 0, -1, -1);

    write_register(REG_WIDTH, 9'd40);
    write_register(REG_HEIGHT, 9'd30);
    test_random_traffic(20, 0, 73, -1, -1);
    test_random_traffic(20, 31, 31, -1, 10);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    wait_idle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
